>>> rtl/rrcs_pkg.sv
// Shared types and constants of the ring relay chunk sequencer.
package rrcs_pkg;

  // Ring and link limits
  localparam int unsigned MaxRing  = 16;
  localparam int unsigned MaxLinks = 8;

  // Field widths
  localparam int unsigned StreamW = 4;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned RingW   = 5;
  localparam int unsigned LinksW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned LinkW   = StreamW - 1;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 5;

  // Command queue depth between front and back
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_RING_SIZE    = 2'd0,
    CFG_LINK_COUNT   = 2'd1,
    CFG_OWN_POSITION = 2'd2
  } cfg_idx_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic               cw;      // stream runs clockwise
    logic [StreamW-1:0] stream;
    logic [LinkW-1:0]   link;
    logic [RingW-1:0]   extent;  // clamped ring size
    logic [IndexW-1:0]  half;    // m = extent / 2
    logic [IndexW-1:0]  pos;     // own position reduced mod extent
    logic [LinksW-1:0]  links;   // clamped link count
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

endpackage

>>> rtl/rrcs_front.sv
// Front end: configuration registers, request acceptance and classification.
module rrcs_front import rrcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push_i,
  input  logic [StreamW-1:0]  stream_number_i,
  output logic                cmd_wr_o,
  output cmd_t                cmd_o
);

  logic [RingW-1:0]  ring_size_q;
  logic [LinksW-1:0] link_count_q;
  logic [IndexW-1:0] own_position_q;

  logic [RingW-1:0]  extent;
  logic [IndexW-1:0] half;
  logic [LinksW-1:0] links;
  logic [RingW-1:0]  pos_red;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q    <= RingW'(8);
      link_count_q   <= LinksW'(1);
      own_position_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RING_SIZE:    ring_size_q    <= cfg_wdata_i[RingW-1:0];
        CFG_LINK_COUNT:   link_count_q   <= cfg_wdata_i[LinksW-1:0];
        CFG_OWN_POSITION: own_position_q <= cfg_wdata_i[IndexW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp ring size and links, derive half extent and reduced position
  always_comb begin
    extent  = (ring_size_q > RingW'(MaxRing)) ? RingW'(MaxRing) : ring_size_q;
    links   = (link_count_q > LinksW'(MaxLinks)) ? LinksW'(MaxLinks) : link_count_q;
    half    = extent[RingW-1:1];
    pos_red = {1'b0, own_position_q};
    // extent is at least four whenever the request is kept, so three steps suffice
    for (int i = 0; i < 3; i++) begin
      if (pos_red >= extent) begin
        pos_red = pos_red - extent;
      end
    end
  end

  // Classify the request; drop it when the ring yields no chunk
  always_comb begin
    cmd_o.cw     = ~stream_number_i[0];
    cmd_o.stream = stream_number_i;
    cmd_o.link   = stream_number_i[StreamW-1:1];
    cmd_o.extent = extent;
    cmd_o.half   = half;
    cmd_o.pos    = pos_red[IndexW-1:0];
    cmd_o.links  = links;
    cmd_wr_o     = push_i && (half >= IndexW'(2));
  end

endmodule

>>> rtl/rrcs_cmd_fifo.sv
// Short command queue between the front and the back end.
module rrcs_cmd_fifo import rrcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q;
  logic [CmdPtrW-1:0] rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_wr;
  logic               do_rd;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CmdCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CmdCntW'(1);
      end
    end
  end

endmodule

>>> rtl/rrcs_back.sv
// Back end: walks src/dst offsets, registers one descriptor per cycle unless stalled.
module rrcs_back import rrcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  cmd_t               cmd_i,
  output logic               cmd_rd_o,
  output logic               empty,
  input  logic               pop,
  output logic [IndexW-1:0]  origin_index_o,
  output logic [IndexW-1:0]  target_index_o,
  output logic [IndexW-1:0]  share_index_o,
  output logic [CountW-1:0]  share_count_o,
  output logic               final_chunk_o
);

  seq_state_e        state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [IndexW-1:0] sm_q, sm_d;
  logic [IndexW-1:0] dm_q, dm_d;

  logic              out_valid_q;
  logic              take;
  logic              emit;
  logic              last;
  logic              opposite;
  logic [IndexW-1:0] sm_inc;
  logic [IndexW-1:0] origin;
  logic [IndexW-1:0] target;

  // Step offset along the ring and wrap once
  function automatic logic [IndexW-1:0] ring_step(logic [IndexW-1:0] p,
                                                   logic [RingW-1:0]  ext,
                                                   logic [IndexW-1:0] off,
                                                   logic              fwd);
    logic [RingW:0] sum;
    if (fwd) begin
      sum = {2'b00, p} + {2'b00, off};
    end else begin
      sum = {2'b00, p} + {1'b0, ext} - {2'b00, off};
    end
    if (sum >= {1'b0, ext}) begin
      sum = sum - {1'b0, ext};
    end
    return sum[IndexW-1:0];
  endfunction

  assign take     = !out_valid_q || pop;
  assign emit     = (state_q == ST_RUN) && take;
  assign last     = (dm_q == IndexW'(1)) && (sm_q == cur_q.half - IndexW'(1));
  assign opposite = (dm_q + sm_q) == cur_q.half;
  assign sm_inc   = sm_q + IndexW'(1);
  assign origin   = ring_step(cur_q.pos, cur_q.extent, sm_q, !cur_q.cw);
  assign target   = ring_step(cur_q.pos, cur_q.extent, dm_q, cur_q.cw);
  assign empty    = !out_valid_q;

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sm_q    <= '0;
      dm_q    <= '0;
    end else begin
      state_q <= state_d;
      sm_q    <= sm_d;
      dm_q    <= dm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Load a command, then advance destination offset, then source offset
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    sm_d     = sm_q;
    dm_d     = dm_q;
    cmd_rd_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_rd_o = 1'b1;
          cur_d    = cmd_i;
          sm_d     = IndexW'(1);
          dm_d     = cmd_i.half - IndexW'(1);
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit) begin
          if (last) begin
            state_d = ST_IDLE;
          end else if (dm_q == IndexW'(1)) begin
            sm_d = sm_inc;
            dm_d = cur_q.half - sm_inc;
          end else begin
            dm_d = dm_q - IndexW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Register the descriptor until it is popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      origin_index_o <= origin;
      target_index_o <= target;
      share_index_o  <= opposite ? cur_q.stream : {1'b0, cur_q.link};
      share_count_o  <= opposite ? {cur_q.links, 1'b0} : {1'b0, cur_q.links};
      final_chunk_o  <= last;
    end
  end

endmodule

>>> rtl/ring_relay_chunk_sequencer_core.sv
// Top level of the ring relay chunk sequencer: front, command queue and back end.
//
//  channel   | ports                                   | accepted when
//  ----------+-----------------------------------------+----------------------
//  request   | push, full, stream_number_i             | push && !full
//  result    | empty, pop, origin/target/share/final   | pop && !empty
//  config    | cfg_we_i, cfg_addr_i, cfg_wdata_i       | cfg_we_i
//
// A request yields m*(m-1)/2 descriptors (m = ring size / 2, up to 28), one per cycle
// from the back-end offset walker unless stalled, after it loads the command in idle.
// The front accepts up to two queued requests while the back end is busy; requests on
// rings below four chips produce nothing and are dropped at once.
// Reset restores ring size 8, one link, position 0 and empties every stage.
// A stalled result holds in the output register; the walker waits until it is popped.
module ring_relay_chunk_sequencer_core import rrcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic [StreamW-1:0]  stream_number_i,
  output logic                empty,
  input  logic                pop,
  output logic [IndexW-1:0]   origin_index_o,
  output logic [IndexW-1:0]   target_index_o,
  output logic [IndexW-1:0]   share_index_o,
  output logic [CountW-1:0]   share_count_o,
  output logic                final_chunk_o
);

  logic cmd_wr;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_rd;
  cmd_t cmd_out;
  logic cmd_empty;

  assign full = cmd_full;

  rrcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push_i          (push && !cmd_full),
    .stream_number_i (stream_number_i),
    .cmd_wr_o        (cmd_wr),
    .cmd_o           (cmd_in)
  );

  rrcs_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .rd_i    (cmd_rd),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  rrcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_out),
    .cmd_rd_o       (cmd_rd),
    .empty          (empty),
    .pop            (pop),
    .origin_index_o (origin_index_o),
    .target_index_o (target_index_o),
    .share_index_o  (share_index_o),
    .share_count_o  (share_count_o),
    .final_chunk_o  (final_chunk_o)
  );

endmodule
